// ===== rtl/core/pst_pkg.sv =====
package pst_pkg;

  localparam logic [1:0] CMD_REPORT  = 2'd0;
  localparam logic [1:0] CMD_SUCCESS = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;

  localparam logic [15:0] ERR_TALLY_MAX  = 16'hFFFF;
  localparam logic [31:0] DROP_TALLY_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        enable;
    logic [15:0] threshold;
    logic [15:0] window;
  } cfg_t;

  typedef struct packed {
    logic [15:0] err_tally;
    logic        thr_on;
    logic [31:0] win_begin;
    logic [31:0] drop_tally;
  } entry_t;

  typedef struct packed {
    logic   we;
    logic   set_present;
    logic   clear_all;
    entry_t entry;
  } tbl_wr_t;

  typedef struct packed {
    logic        suppress;
    logic        activated_now;
    logic [31:0] suppressed_total;
  } result_t;

endpackage

// ===== rtl/core/pst_regs.sv =====
module pst_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pst_pkg::cfg_t cfg
);
  import pst_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b1;
      cfg_r.threshold <= 16'd10;
      cfg_r.window    <= 16'd60;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ENABLE:    cfg_r.enable    <= pwdata[0];
        REG_THRESHOLD: cfg_r.threshold <= pwdata[15:0];
        REG_WINDOW:    cfg_r.window    <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE:    prdata = {31'd0, cfg_r.enable};
      REG_THRESHOLD: prdata = {16'd0, cfg_r.threshold};
      REG_WINDOW:    prdata = {16'd0, cfg_r.window};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/pst_table.sv =====
module pst_table #(
  parameter int NUM_SOURCES = 16,
  parameter int IDX_W       = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output pst_pkg::entry_t  rd_entry,
  input  logic [IDX_W-1:0] wr_addr,
  input  pst_pkg::tbl_wr_t wr,
  output logic             present
);
  import pst_pkg::*;

  entry_t                 mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] present_r;

  // fields are only meaningful where the present bit is set
  always_ff @(posedge clk) begin
    if (wr.we) mem[wr_addr] <= wr.entry;
    if (rd_en) rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr.clear_all) begin
      present_r <= '0;
    end else if (wr.set_present) begin
      present_r[wr_addr] <= 1'b1;
    end
  end

  assign present = present_r[wr_addr];

endmodule

// ===== rtl/core/pst_update.sv =====
module pst_update (
  input  logic [1:0]        command,
  input  logic              in_range,
  input  logic              is_error,
  input  logic [31:0]       now_seconds,
  input  logic              present,
  input  pst_pkg::entry_t   entry,
  input  pst_pkg::cfg_t     cfg,
  output pst_pkg::tbl_wr_t  wr,
  output pst_pkg::result_t  res
);
  import pst_pkg::*;

  entry_t      e;
  logic [31:0] elapsed;

  assign elapsed = now_seconds - entry.win_begin;

  always_comb begin
    e                    = entry;
    wr                   = '0;
    res                  = '0;
    if (command == CMD_CLEAR) begin
      wr.clear_all = 1'b1;
    end else if ((command == CMD_REPORT || command == CMD_SUCCESS) && in_range) begin
      if (command == CMD_SUCCESS) begin
        if (present) begin
          e.err_tally = 16'd0;
          e.thr_on    = 1'b0;
          e.win_begin = now_seconds;
          wr.we       = 1'b1;
        end
      end else if (is_error && cfg.enable) begin
        if (!present) begin
          e              = '0;
          e.win_begin    = now_seconds;
          wr.set_present = 1'b1;
        end else if (elapsed >= {16'd0, cfg.window}) begin
          e.err_tally = 16'd0;
          e.thr_on    = 1'b0;
          e.win_begin = now_seconds;
        end
        if (e.err_tally != ERR_TALLY_MAX) e.err_tally = e.err_tally + 16'd1;
        if (!e.thr_on && e.err_tally >= cfg.threshold) begin
          e.thr_on          = 1'b1;
          res.activated_now = 1'b1;
        end else if (e.thr_on) begin
          if (e.drop_tally != DROP_TALLY_MAX) e.drop_tally = e.drop_tally + 32'd1;
          res.suppress = 1'b1;
        end
        wr.we = 1'b1;
      end
      if (present || wr.set_present) res.suppressed_total = e.drop_tally;
    end
    wr.entry = e;
  end

endmodule

// ===== rtl/core/per_source_error_throttle.sv =====
// Per-source error report throttle, fixed time window.
// Input channel (in_*): one beat per command: report, success or table clear,
// with source index, error flag and current time in seconds.
// Output channel (out_*): exactly one result beat per input beat, in order:
// suppress, activated_now and the source's saturating drop count.
// Config: APB registers at 0x0 enable, 0x4 threshold, 0x8 window length;
// pready is tied high, writes land on the access cycle.
// Flow: one item is in flight at a time. The accept edge registers the beat
// and the table read (registered memory output); the update/write-back and
// the result register commit together from the update stage, and in_stall
// holds off the next beat until that commit has happened.
// While out_stall holds, the finished result waits in the output register;
// an item already read from the table waits in the update stage and the
// input stays stalled until the result register can take its beat.
// Reset: configuration returns to enable=1, threshold=10, window=60 and all
// source entries are marked absent at once; no clearing pass is needed.
module per_source_error_throttle #(
  parameter int NUM_SOURCES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_source,
  input  logic        in_is_error,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_suppress,
  output logic        out_activated_now,
  output logic [31:0] out_suppressed_total
);
  import pst_pkg::*;

  localparam int         IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam logic [8:0] NSRC  = 9'(NUM_SOURCES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  cfg_t        cfg;
  logic        st_r, st_nxt;
  logic [1:0]  cmd_r;
  logic [3:0]  src_r;
  logic        err_r;
  logic [31:0] now_r;
  logic        accept, commit, in_range, present;
  entry_t      rd_entry;
  tbl_wr_t     upd_wr, tbl_wr;
  result_t     upd_res, out_res_r;
  logic        out_valid_r;

  pst_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  assign in_stall = (st_r == ST_EXEC);
  assign accept   = in_valid & ~in_stall;
  assign commit   = (st_r == ST_EXEC) & (~out_valid_r | ~out_stall);
  assign in_range = {5'd0, src_r} < NSRC;
  assign tbl_wr   = commit ? upd_wr : '0;

  pst_table #(.NUM_SOURCES(NUM_SOURCES), .IDX_W(IDX_W)) u_table (
    .clk, .rst_n,
    .rd_en    (accept),
    .rd_addr  (IDX_W'(in_source)),
    .rd_entry (rd_entry),
    .wr_addr  (IDX_W'(src_r)),
    .wr       (tbl_wr),
    .present  (present)
  );

  pst_update u_update (
    .command     (cmd_r),
    .in_range    (in_range),
    .is_error    (err_r),
    .now_seconds (now_r),
    .present     (present),
    .entry       (rd_entry),
    .cfg         (cfg),
    .wr          (upd_wr),
    .res         (upd_res)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_EXEC;
      ST_EXEC: if (commit) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      src_r <= in_source;
      err_r <= in_is_error;
      now_r <= in_now_seconds;
    end
    if (commit) out_res_r <= upd_res;
  end

  assign out_valid            = out_valid_r;
  assign out_suppress         = out_res_r.suppress;
  assign out_activated_now    = out_res_r.activated_now;
  assign out_suppressed_total = out_res_r.suppressed_total;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (st_r == ST_EXEC))
    else $error("accepted beat did not enter update stage");

  a_rose_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == ST_EXEC))
    else $error("result appeared without an item in update stage");

  a_sup_act_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_suppress && out_activated_now))
    else $error("result both suppressed and activating");

  a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && st_r == ST_IDLE))
    else $error("committed item did not reach output register");

endmodule
